### rtl/cap_pkg.sv
`default_nettype none

package cap_pkg;

  localparam int unsigned NUM_ENTRIES = 6;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned TALLY_W     = 16;
  localparam int unsigned COL_W       = 7;
  localparam int unsigned ROW_W       = 9;
  localparam int unsigned SQ_W        = 2 * CH_W;
  localparam int unsigned DIST_W      = SQ_W + 2;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned DIV_STEP_W  = 3;

  // APB register map: palette entry i at byte address 4*i
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REG_LSB     = 2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef logic [NUM_ENTRIES-1:0][COLOR_W-1:0] palette_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEARCH,
    BK_TALLY,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic pop;
    logic div_step;
    logic search_step;
    logic tally_step;
    logic out_take;
  } back_ctrl_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

### rtl/cap_front.sv
`default_nettype none

module cap_front import cap_pkg::*; #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned SUM_W = 21,
  parameter int unsigned MAX_CELL_PIXELS = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [CH_W-1:0]     red_i,
  input  wire logic [CH_W-1:0]     green_i,
  input  wire logic [CH_W-1:0]     blue_i,
  input  wire logic                last_of_cell_i,
  input  wire logic                frame_start_i,
  output logic                     push_o,
  output logic                     job_clear_o,
  output logic [CNT_W-1:0]         job_count_o,
  output logic [SUM_W-1:0]         job_red_o,
  output logic [SUM_W-1:0]         job_green_o,
  output logic [SUM_W-1:0]         job_blue_o
);

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_CELL_PIXELS);

  logic [SUM_W-1:0] red_sum_q, red_sum_d;
  logic [SUM_W-1:0] green_sum_q, green_sum_d;
  logic [SUM_W-1:0] blue_sum_q, blue_sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             clr_pend_q, clr_pend_d;
  logic             add;
  logic [SUM_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CNT_W-1:0] count_nxt;

  // pixels past the count limit are dropped but may still end the cell
  assign add       = (count_q < CntMax);
  assign red_nxt   = add ? red_sum_q   + SUM_W'(red_i)   : red_sum_q;
  assign green_nxt = add ? green_sum_q + SUM_W'(green_i) : green_sum_q;
  assign blue_nxt  = add ? blue_sum_q  + SUM_W'(blue_i)  : blue_sum_q;
  assign count_nxt = add ? count_q + CNT_W'(1) : count_q;

  assign push_o      = accept_i && last_of_cell_i;
  assign job_clear_o = clr_pend_q || frame_start_i;
  assign job_count_o = count_nxt;
  assign job_red_o   = red_nxt;
  assign job_green_o = green_nxt;
  assign job_blue_o  = blue_nxt;

  always_comb begin
    red_sum_d   = red_sum_q;
    green_sum_d = green_sum_q;
    blue_sum_d  = blue_sum_q;
    count_d     = count_q;
    clr_pend_d  = clr_pend_q;
    if (accept_i) begin
      if (last_of_cell_i) begin
        red_sum_d   = '0;
        green_sum_d = '0;
        blue_sum_d  = '0;
        count_d     = '0;
        clr_pend_d  = 1'b0;
      end else begin
        red_sum_d   = red_nxt;
        green_sum_d = green_nxt;
        blue_sum_d  = blue_nxt;
        count_d     = count_nxt;
        clr_pend_d  = clr_pend_q || frame_start_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
      count_q     <= '0;
      clr_pend_q  <= 1'b0;
    end else begin
      red_sum_q   <= red_sum_d;
      green_sum_q <= green_sum_d;
      blue_sum_q  <= blue_sum_d;
      count_q     <= count_d;
      clr_pend_q  <= clr_pend_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cap_queue.sv
`default_nettype none

module cap_queue #(
  parameter int unsigned WIDTH = 80
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  // two-entry queue
  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            fill_q;
  logic                  do_push, do_pop;

  assign full_o     = fill_q[1];
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cap_back.sv
`default_nettype none

module cap_back import cap_pkg::*; #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned SUM_W = 21,
  parameter int unsigned PALETTE_SIZE = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                job_valid_i,
  output logic                     job_pop_o,
  input  wire logic                job_clear_i,
  input  wire logic [CNT_W-1:0]    job_count_i,
  input  wire logic [SUM_W-1:0]    job_red_i,
  input  wire logic [SUM_W-1:0]    job_green_i,
  input  wire logic [SUM_W-1:0]    job_blue_i,
  input  wire logic [COL_W-1:0]    job_col_i,
  input  wire logic [ROW_W-1:0]    job_row_i,
  input  wire palette_t            palette_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [CH_W-1:0]          avg_red_o,
  output logic [CH_W-1:0]          avg_green_o,
  output logic [CH_W-1:0]          avg_blue_o,
  output logic [IDX_W-1:0]         nearest_index_o,
  output logic [TALLY_W-1:0]       tile_tally_o,
  output logic [COL_W-1:0]         out_cell_col_o,
  output logic [ROW_W-1:0]         out_cell_row_o
);

  localparam logic [IDX_W-1:0] LastEntry = IDX_W'(PALETTE_SIZE - 1);

  back_state_e state_q, state_d;
  back_ctrl_t  ctrl;

  logic [NUM_CH-1:0][SUM_W-1:0] rem_q;
  logic [NUM_CH-1:0][CH_W-1:0]  quo_q;
  logic [CNT_W-1:0]             count_q;
  logic [DIV_STEP_W-1:0]        step_q;
  logic [IDX_W-1:0]             ent_q;
  logic [IDX_W-1:0]             best_q;
  logic [DIST_W-1:0]            best_dist_q;
  logic [COL_W-1:0]             col_q;
  logic [ROW_W-1:0]             row_q;
  logic [NUM_ENTRIES-1:0][TALLY_W-1:0] tally_q;
  logic                         out_valid_q;
  logic [TALLY_W-1:0]           out_tally_q;

  logic [SUM_W-1:0]             shifted;
  logic [COLOR_W-1:0]           color;
  logic [DIST_W-1:0]            entry_dist;
  logic [TALLY_W-1:0]           tally_inc;

  // ---- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (job_valid_i) state_d = BK_DIV;
      BK_DIV:    if (step_q == '0) state_d = BK_SEARCH;
      BK_SEARCH: if (ent_q == LastEntry) state_d = BK_TALLY;
      BK_TALLY:  state_d = BK_OUT;
      BK_OUT:    if (out_ready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // ---- outputs of the sequencer
  always_comb begin
    ctrl = '0;
    case (state_q)
      BK_IDLE:   ctrl.pop = job_valid_i;
      BK_DIV:    ctrl.div_step = 1'b1;
      BK_SEARCH: ctrl.search_step = 1'b1;
      BK_TALLY:  ctrl.tally_step = 1'b1;
      BK_OUT:    ctrl.out_take = out_ready_i;
      default:   ctrl = '0;
    endcase
  end

  assign job_pop_o = ctrl.pop;

  // restoring division, one quotient bit per cycle for all three channels
  assign shifted = SUM_W'(count_q) << step_q;

  // squared distance of the averaged color to one palette entry
  assign color      = palette_i[ent_q];
  assign entry_dist = DIST_W'(sq_diff(color[23:16], quo_q[0]))
                    + DIST_W'(sq_diff(color[15:8],  quo_q[1]))
                    + DIST_W'(sq_diff(color[7:0],   quo_q[2]));

  assign tally_inc = (tally_q[best_q] == TALLY_MAX) ? TALLY_MAX
                                                    : tally_q[best_q] + TALLY_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl.pop) begin
      rem_q[0] <= job_red_i;
      rem_q[1] <= job_green_i;
      rem_q[2] <= job_blue_i;
      quo_q    <= '0;
      count_q  <= job_count_i;
      step_q   <= DIV_STEP_W'(CH_W - 1);
      col_q    <= job_col_i;
      row_q    <= job_row_i;
      ent_q    <= '0;
    end
    if (ctrl.div_step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (rem_q[c] >= shifted) begin
          rem_q[c]         <= rem_q[c] - shifted;
          quo_q[c][step_q] <= 1'b1;
        end
      end
      step_q <= step_q - DIV_STEP_W'(1);
    end
    if (ctrl.search_step) begin
      if (ent_q == '0 || entry_dist < best_dist_q) begin
        best_dist_q <= entry_dist;
        best_q      <= ent_q;
      end
      ent_q <= ent_q + IDX_W'(1);
    end
    if (ctrl.tally_step) begin
      out_tally_q <= tally_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // frame start clears tallies ahead of this cell's count
      if (ctrl.pop && job_clear_i) begin
        tally_q <= '0;
      end
      if (ctrl.tally_step) begin
        tally_q[best_q] <= tally_inc;
        out_valid_q     <= 1'b1;
      end else if (ctrl.out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign avg_red_o       = quo_q[0];
  assign avg_green_o     = quo_q[1];
  assign avg_blue_o      = quo_q[2];
  assign nearest_index_o = best_q;
  assign tile_tally_o    = out_tally_q;
  assign out_cell_col_o  = col_q;
  assign out_cell_row_o  = row_q;

endmodule

`default_nettype wire

### rtl/cell_average_palette_quantizer_top.sv
`default_nettype none

// Cell-average palette quantizer. Pixels come in one word per cycle while
// in_ready_o is high, grouped by mosaic cell, with last_of_cell_i on the
// final pixel. The front end sums red, green and blue and counts pixels at
// full rate (one pixel per cycle, no stall while queue space is free); a
// cell stops accumulating once its count reaches MAX_CELL_PIXELS. At the last
// pixel the cell's sums go into a two-entry queue. The back end takes one
// cell at a time: it loads the cell, runs restoring division (one mean bit
// per cycle, three channels in parallel), searches for the nearest color
// (one palette entry per cycle, one set of three 8x8 squarers), bumps the
// tally, and then holds the result word in its output register until taken.
// Pixel input stalls only when two finished cells are already waiting. Ties
// in distance go to the lowest palette index. Tallies are per frame: a word
// with frame_start_i set clears all of them before its own cell is counted;
// each saturates at 65535. Palette colors are APB registers at 0x00..0x14
// (red 23:16, green 15:8, blue 7:0); the user must write them only while
// idle, as the block does not enforce this.

module cell_average_palette_quantizer_top import cap_pkg::*; #(
  parameter int unsigned MAX_CELL_PIXELS = 4096,
  parameter int unsigned PALETTE_SIZE    = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // pixel input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CH_W-1:0]    red_i,
  input  wire logic [CH_W-1:0]    green_i,
  input  wire logic [CH_W-1:0]    blue_i,
  input  wire logic               last_of_cell_i,
  input  wire logic               frame_start_i,
  input  wire logic [COL_W-1:0]   cell_col_i,
  input  wire logic [ROW_W-1:0]   cell_row_i,
  // cell result
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CH_W-1:0]         avg_red_o,
  output logic [CH_W-1:0]         avg_green_o,
  output logic [CH_W-1:0]         avg_blue_o,
  output logic [IDX_W-1:0]        nearest_index_o,
  output logic [TALLY_W-1:0]      tile_tally_o,
  output logic [COL_W-1:0]        out_cell_col_o,
  output logic [ROW_W-1:0]        out_cell_row_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CELL_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + CH_W;
  localparam int unsigned JOB_W = 1 + COL_W + ROW_W + CNT_W + NUM_CH * SUM_W;

  // ---- configuration registers
  palette_t          palette_q;
  logic [IDX_W-1:0]  reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:REG_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
    end else if (cfg_wr && (reg_idx < IDX_W'(NUM_ENTRIES))) begin
      palette_q[reg_idx] <= pwdata[COLOR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < IDX_W'(NUM_ENTRIES)) begin
      prdata = DATA_W'(palette_q[reg_idx]);
    end
  end

  // ---- front end: accumulate pixels of the current cell
  logic             accept;
  logic             q_full;
  logic             push;
  logic             f_clear;
  logic [CNT_W-1:0] f_count;
  logic [SUM_W-1:0] f_red, f_green, f_blue;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  cap_front #(
    .CNT_W           (CNT_W),
    .SUM_W           (SUM_W),
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .last_of_cell_i (last_of_cell_i),
    .frame_start_i  (frame_start_i),
    .push_o         (push),
    .job_clear_o    (f_clear),
    .job_count_o    (f_count),
    .job_red_o      (f_red),
    .job_green_o    (f_green),
    .job_blue_o     (f_blue)
  );

  // ---- finished-cell queue
  logic [JOB_W-1:0] push_job, pop_job;
  logic             q_valid;
  logic             q_pop;
  logic             b_clear;
  logic [COL_W-1:0] b_col;
  logic [ROW_W-1:0] b_row;
  logic [CNT_W-1:0] b_count;
  logic [SUM_W-1:0] b_red, b_green, b_blue;

  assign push_job = {f_clear, cell_col_i, cell_row_i, f_count, f_blue, f_green, f_red};
  assign {b_clear, b_col, b_row, b_count, b_blue, b_green, b_red} = pop_job;

  cap_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  // ---- back end: divide, search, tally
  cap_back #(
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_pop_o       (q_pop),
    .job_clear_i     (b_clear),
    .job_count_i     (b_count),
    .job_red_i       (b_red),
    .job_green_i     (b_green),
    .job_blue_i      (b_blue),
    .job_col_i       (b_col),
    .job_row_i       (b_row),
    .palette_i       (palette_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .avg_red_o       (avg_red_o),
    .avg_green_o     (avg_green_o),
    .avg_blue_o      (avg_blue_o),
    .nearest_index_o (nearest_index_o),
    .tile_tally_o    (tile_tally_o),
    .out_cell_col_o  (out_cell_col_o),
    .out_cell_row_o  (out_cell_row_o)
  );

`ifndef NO_ASSERTIONS
  // a finished cell must never be pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("cell queue overflow");

  // search never picks an entry beyond the configured palette
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nearest_index_o < IDX_W'(PALETTE_SIZE)))
    else $error("nearest index out of range");

  // the reported tally already counts this cell
  a_tally_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tile_tally_o != '0))
    else $error("zero tally on result");
`endif

endmodule

`default_nettype wire
